// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lis_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    final_res;
    logic                    overflowed;
  } out_res_t;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic step;
  } cmp_ctrl_t;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_DRAIN   = 8'b0000_0100,
    S_WRITE   = 8'b0000_1000,
    S_WALK_RD = 8'b0001_0000,
    S_WALK_WR = 8'b0010_0000,
    S_EMIT_RD = 8'b0100_0000,
    S_EMIT_LD = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/lis_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lis_cmp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Shared compare/update unit: folds one earlier element per step into the
// best length and predecessor of the element being stored.
module lis_cmp_unit #(
  parameter int unsigned AW = 6
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lis_pkg::cmp_ctrl_t              ctrl_i,
  input  wire logic signed [lis_pkg::VAL_W-1:0] new_val_i,
  input  wire logic signed [lis_pkg::VAL_W-1:0] old_val_i,
  input  wire logic [lis_pkg::LEN_W-1:0]       old_len_i,
  input  wire logic [AW-1:0]                   old_idx_i,
  output logic      [lis_pkg::LEN_W-1:0]       best_o,
  output logic      [AW-1:0]                   pred_o
);

  import lis_pkg::*;

  logic [LEN_W-1:0] best_q, best_d;
  logic [AW-1:0]    pred_q, pred_d;
  logic [LEN_W-1:0] cand;

  assign cand = old_len_i + LEN_W'(1);

  always_comb begin
    best_d = best_q;
    pred_d = pred_q;
    if (ctrl_i.clear) begin
      best_d = LEN_W'(1);
      pred_d = '0;
    end else if (ctrl_i.step && (new_val_i > old_val_i) && (cand >= best_q)) begin
      // latest earlier index wins a tie
      best_d = cand;
      pred_d = old_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= LEN_W'(1);
      pred_q <= '0;
    end else begin
      best_q <= best_d;
      pred_q <= pred_d;
    end
  end

  assign best_o = best_q;
  assign pred_o = pred_q;

  `ASSERT_ALWAYS(a_best_nonzero, clk_i, rst_ni, best_q != '0, "best length fell to zero")
  `ASSERT_IMPLY(a_clear_restarts, clk_i, rst_ni, $past(ctrl_i.clear), best_q == LEN_W'(1),
    "best length not restarted after clear")

endmodule

`default_nettype wire

// ===== hdl/longest_increasing_subsequence.sv =====
// Channel | Dir | Handshake                 | Payload
// in      | in  | in_valid_i / in_ready_o   | in_req_i  (value, last)
// out     | out | out_valid_o / out_ready_i | out_res_o (element, length, final_res,
//         |     |                           |            overflowed)
//
// Storing an element runs one compare a cycle through the shared compare unit
// against the item RAM read port, one per earlier element; S_WRITE then stores it.
// A dropped item is not stored. After the last item the predecessor walk passes
// S_WALK_RD, S_WALK_WR per element, then each result is read from the reverse RAM.
// Input is not ready while a sequence is being scanned, walked or emitted.
// Reset clears the control state only; the RAMs are never cleared.
// A stalled output holds its register; the next sequence may start loading meanwhile.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module longest_increasing_subsequence #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lis_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lis_pkg::out_res_t      out_res_o
);

  import lis_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_ITEMS);
  localparam int unsigned CW     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ITEM_W = VAL_W + LEN_W + AW;

  state_e           state_q, state_d;
  in_req_t          in_q, in_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             dropped_q, dropped_d;
  logic [LEN_W-1:0] maxlen_q, maxlen_d;
  logic [AW-1:0]    end_q, end_d;
  logic [AW-1:0]    j_q, j_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d;
  logic [CW-1:0]    k_q, k_d;
  logic [AW-1:0]    idx_q, idx_d;
  out_res_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic              in_acc;
  logic [CW-1:0]     cnt_m1, k_m1, k_p1;
  logic [LEN_W-1:0]  new_max;
  logic [AW-1:0]     new_end;
  cmp_ctrl_t         cmp_ctrl;
  logic [LEN_W-1:0]  best;
  logic [AW-1:0]     pred;

  logic              item_we, item_re;
  logic [AW-1:0]     item_raddr;
  logic [ITEM_W-1:0] item_wdata, item_rdata;
  logic signed [VAL_W-1:0] rd_val;
  logic [LEN_W-1:0]  rd_len;
  logic [AW-1:0]     rd_pred;

  logic              rev_we, rev_re;
  logic [VAL_W-1:0]  rev_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign cnt_m1 = cnt_q - CW'(1);
  assign k_m1   = k_q - CW'(1);
  assign k_p1   = k_q + CW'(1);

  assign rd_val  = $signed(item_rdata[ITEM_W-1 -: VAL_W]);
  assign rd_len  = item_rdata[AW +: LEN_W];
  assign rd_pred = item_rdata[AW-1:0];

  // first index with the greatest length wins
  assign new_max = (best > maxlen_q) ? best : maxlen_q;
  assign new_end = (best > maxlen_q) ? cnt_q[AW-1:0] : end_q;

  assign item_wdata = {in_q.value, best, pred};
  assign item_we    = (state_q == S_WRITE);
  assign item_re    = (state_q == S_SCAN) || (state_q == S_WALK_RD);
  assign item_raddr = (state_q == S_SCAN) ? j_q : idx_q;
  assign rev_we     = (state_q == S_WALK_WR);
  assign rev_re     = (state_q == S_EMIT_RD);

  assign cmp_ctrl.clear = in_acc;
  assign cmp_ctrl.step  = cmp_vld_q;

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    maxlen_d    = maxlen_q;
    end_d       = end_q;
    j_d         = j_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    k_d         = k_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_d = in_req_i;
          if (cnt_q == CW'(MAX_ITEMS)) begin
            // full: drop the request, but a last one still closes the sequence
            dropped_d = 1'b1;
            if (in_req_i.last) begin
              k_d     = CW'(maxlen_q);
              idx_d   = end_q;
              state_d = S_WALK_RD;
            end
          end else if (cnt_q == '0) begin
            state_d = S_WRITE;
          end else begin
            j_d     = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = j_q;
        j_d       = j_q + AW'(1);
        if (j_q == cnt_m1[AW-1:0]) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        maxlen_d = new_max;
        end_d    = new_end;
        cnt_d    = cnt_q + CW'(1);
        if (in_q.last) begin
          k_d     = CW'(new_max);
          idx_d   = new_end;
          state_d = S_WALK_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WALK_RD: begin
        state_d = S_WALK_WR;
      end
      S_WALK_WR: begin
        idx_d = rd_pred;
        k_d   = k_m1;
        if (k_q == CW'(1)) begin
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.element    = $signed(rev_rdata);
          out_d.length     = maxlen_q;
          out_d.final_res  = (k_p1 == CW'(maxlen_q));
          out_d.overflowed = dropped_q;
          out_valid_d      = 1'b1;
          k_d              = k_p1;
          if (k_p1 == CW'(maxlen_q)) begin
            cnt_d     = '0;
            dropped_d = 1'b0;
            maxlen_d  = '0;
            end_d     = '0;
            state_d   = S_IDLE;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      maxlen_q    <= '0;
      end_q       <= '0;
      j_q         <= '0;
      cmp_vld_q   <= 1'b0;
      k_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dropped_q   <= dropped_d;
      maxlen_q    <= maxlen_d;
      end_q       <= end_d;
      j_q         <= j_d;
      cmp_vld_q   <= cmp_vld_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    cmp_idx_q <= cmp_idx_d;
    out_q     <= out_d;
  end

  lis_cmp_unit #(
    .AW (AW)
  ) u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cmp_ctrl),
    .new_val_i (in_q.value),
    .old_val_i (rd_val),
    .old_len_i (rd_len),
    .old_idx_i (cmp_idx_q),
    .best_o    (best),
    .pred_o    (pred)
  );

  lis_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (MAX_ITEMS)
  ) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (item_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (item_wdata),
    .re_i    (item_re),
    .raddr_i (item_raddr),
    .rdata_o (item_rdata)
  );

  lis_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ITEMS)
  ) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (rev_we),
    .waddr_i (k_m1[AW-1:0]),
    .wdata_i (rd_val),
    .re_i    (rev_re),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (rev_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `ASSERT_ALWAYS(a_cnt_in_range, clk_i, rst_ni, cnt_q <= CW'(MAX_ITEMS),
    "item count beyond capacity")
  `ASSERT_ALWAYS(a_maxlen_le_cnt, clk_i, rst_ni, maxlen_q <= LEN_W'(cnt_q),
    "longest length exceeds stored items")
  `ASSERT_IMPLY(a_walk_has_steps, clk_i, rst_ni, state_q == S_WALK_RD, k_q != '0,
    "predecessor walk entered with no steps left")
  `ASSERT_IMPLY(a_emit_in_range, clk_i, rst_ni, state_q == S_EMIT_RD,
    k_q < CW'(maxlen_q), "emit index past subsequence length")

endmodule

`default_nettype wire
